### design/lrpw_pkg.sv
// Package for the line rasterizer pixel writer: widths, register indexes,
// item kinds, pixel size codes and the color packing function.
// Has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package lrpw_pkg;

  localparam int unsigned COORD_BITS_DEF = 15;
  localparam int unsigned ADDR_BITS_DEF  = 29;

  localparam int unsigned SCREEN_BITS = 14;
  localparam int unsigned BPP_BITS    = 4;
  localparam int unsigned STRIDE_BITS = 16;
  localparam int unsigned COLOR_BITS  = 24;
  localparam int unsigned BYTES_BITS  = 32;
  localparam int unsigned COUNT_BITS  = 3;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = SCREEN_BITS'(640);
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = SCREEN_BITS'(480);
  localparam logic [BPP_BITS-1:0]    BPP_RST           = BPP_BITS'(4);
  localparam logic [STRIDE_BITS-1:0] STRIDE_RST        = STRIDE_BITS'(2560);

  localparam logic [BPP_BITS-1:0] BPP_RGB565 = BPP_BITS'(2);
  localparam logic [BPP_BITS-1:0] BPP_RGB888 = BPP_BITS'(3);
  localparam logic [BPP_BITS-1:0] BPP_XRGB   = BPP_BITS'(4);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_BYTES_PER_PIX = 2'd2,
    CFG_ROW_STRIDE    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic last;
    logic idle;
  } px_flags_t;

  function automatic logic [BYTES_BITS-1:0] pack_color(
    input logic [BPP_BITS-1:0]   bpp,
    input logic [COLOR_BITS-1:0] rgb
  );
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [BYTES_BITS-1:0] res;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    res = '0;
    if (bpp == BPP_XRGB) begin
      res = {ALPHA_OPAQUE, r, g, b};
    end else if (bpp == BPP_RGB888) begin
      res = {8'h00, r, g, b};
    end else if (bpp == BPP_RGB565) begin
      res = {16'h0000, r[7:3], g[7:2], b[7:3]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/lrpw_walker.sv
// Bresenham walk: holds the line state, takes start and step words and
// registers the current pixel with its color and flags. Uses lrpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrpw_walker import lrpw_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         kind_i,
  input  wire logic signed [COORD_BITS-1:0] start_x_i,
  input  wire logic signed [COORD_BITS-1:0] start_y_i,
  input  wire logic signed [COORD_BITS-1:0] finish_x_i,
  input  wire logic signed [COORD_BITS-1:0] finish_y_i,
  input  wire logic [COLOR_BITS-1:0]        color_rgb_i,
  output logic                              pix_valid_o,
  input  wire logic                         pix_ready_i,
  output logic signed [COORD_BITS-1:0]      pix_x_o,
  output logic signed [COORD_BITS-1:0]      pix_y_o,
  output logic [COLOR_BITS-1:0]             pix_color_o,
  output px_flags_t                         pix_flags_o
);

  localparam int unsigned SPW = COORD_BITS + 1;
  localparam int unsigned ERW = COORD_BITS + 2;
  localparam int unsigned E2W = COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic                         step_left_q, step_left_d, step_up_q, step_up_d;
  logic signed [SPW-1:0]        span_x_q, span_x_d, neg_span_y_q, neg_span_y_d;
  logic signed [ERW-1:0]        err_q, err_d;
  logic [COLOR_BITS-1:0]        color_q, color_d;
  logic                         active_q, active_d;

  logic                         pv_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [COLOR_BITS-1:0]        pc_q;
  px_flags_t                    pf_q, pf_d;

  logic                         accept;
  logic signed [SPW-1:0]        dx, dy;
  logic signed [E2W-1:0]        e2, err_sum;
  logic                         move_x, move_y;

  assign in_ready_o = !pv_q || pix_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign dx = SPW'(finish_x_i) - SPW'(start_x_i);
  assign dy = SPW'(finish_y_i) - SPW'(start_y_i);
  assign e2 = E2W'(err_q) <<< 1;
  assign move_x = e2 >= E2W'(neg_span_y_q);
  assign move_y = e2 <= E2W'(span_x_q);

  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    tgt_x_d      = tgt_x_q;
    tgt_y_d      = tgt_y_q;
    step_left_d  = step_left_q;
    step_up_d    = step_up_q;
    span_x_d     = span_x_q;
    neg_span_y_d = neg_span_y_q;
    err_d        = err_q;
    color_d      = color_q;
    active_d     = active_q;
    pf_d         = '0;
    err_sum      = E2W'(err_q);
    if (kind_i == KIND_START) begin
      cur_x_d      = start_x_i;
      cur_y_d      = start_y_i;
      tgt_x_d      = finish_x_i;
      tgt_y_d      = finish_y_i;
      step_left_d  = !(start_x_i < finish_x_i);
      step_up_d    = !(start_y_i < finish_y_i);
      span_x_d     = (dx < 0) ? -dx : dx;
      neg_span_y_d = (dy < 0) ? dy : -dy;
      err_d        = ERW'(span_x_d) + ERW'(neg_span_y_d);
      color_d      = color_rgb_i;
      pf_d.last    = (start_x_i == finish_x_i) && (start_y_i == finish_y_i);
      active_d     = !pf_d.last;
    end else if (!active_q) begin
      pf_d.idle = 1'b1;
    end else begin
      if (move_x) begin
        err_sum = err_sum + E2W'(neg_span_y_q);
        cur_x_d = step_left_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
      end
      if (move_y) begin
        err_sum = err_sum + E2W'(span_x_q);
        cur_y_d = step_up_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
      end
      err_d     = err_sum[ERW-1:0];
      pf_d.last = (cur_x_d == tgt_x_q) && (cur_y_d == tgt_y_q);
      active_d  = !pf_d.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      tgt_x_q      <= '0;
      tgt_y_q      <= '0;
      step_left_q  <= 1'b0;
      step_up_q    <= 1'b0;
      span_x_q     <= '0;
      neg_span_y_q <= '0;
      err_q        <= '0;
      color_q      <= '0;
      active_q     <= 1'b0;
      pv_q         <= 1'b0;
    end else begin
      if (accept) begin
        cur_x_q      <= cur_x_d;
        cur_y_q      <= cur_y_d;
        tgt_x_q      <= tgt_x_d;
        tgt_y_q      <= tgt_y_d;
        step_left_q  <= step_left_d;
        step_up_q    <= step_up_d;
        span_x_q     <= span_x_d;
        neg_span_y_q <= neg_span_y_d;
        err_q        <= err_d;
        color_q      <= color_d;
        active_q     <= active_d;
      end
      if (in_ready_o) begin
        pv_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= cur_x_d;
      py_q <= cur_y_d;
      pc_q <= color_d;
      pf_q <= pf_d;
    end
  end

  assign pix_valid_o = pv_q;
  assign pix_x_o     = px_q;
  assign pix_y_o     = py_q;
  assign pix_color_o = pc_q;
  assign pix_flags_o = pf_q;

endmodule

`default_nettype wire

### design/lrpw_writer.sv
// Pixel writer: clips the pixel, forms the byte address in two stages
// and packs the color. Uses lrpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrpw_writer import lrpw_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [SCREEN_BITS-1:0]       screen_width_i,
  input  wire logic [SCREEN_BITS-1:0]       screen_height_i,
  input  wire logic [BPP_BITS-1:0]          bytes_per_pixel_i,
  input  wire logic [STRIDE_BITS-1:0]       row_stride_i,
  input  wire logic                         pix_valid_i,
  output logic                              pix_ready_o,
  input  wire logic signed [COORD_BITS-1:0] pix_x_i,
  input  wire logic signed [COORD_BITS-1:0] pix_y_i,
  input  wire logic [COLOR_BITS-1:0]        pix_color_i,
  input  wire px_flags_t                    pix_flags_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              write_enable_o,
  output logic [ADDR_BITS-1:0]              byte_address_o,
  output logic [BYTES_BITS-1:0]             pixel_bytes_o,
  output logic [COUNT_BITS-1:0]             byte_count_o,
  output logic                              last_pixel_o,
  output logic                              line_idle_o
);

  localparam int unsigned MW   = COORD_BITS - 1;
  localparam int unsigned CMPW = (MW > SCREEN_BITS) ? MW : SCREEN_BITS;
  localparam int unsigned YPW  = MW + STRIDE_BITS;
  localparam int unsigned XPW  = MW + BPP_BITS;
  localparam int unsigned SW   = (ADDR_BITS > YPW + 1) ? ADDR_BITS : YPW + 1;

  logic [MW-1:0]  xm, ym;
  logic           on_screen, sized, wen;
  logic           b_ready, c_ready;

  logic                  bv_q, bw_q;
  logic [YPW-1:0]        by_q;
  logic [XPW-1:0]        bx_q;
  logic [BYTES_BITS-1:0] bb_q;
  logic [COUNT_BITS-1:0] bn_q;
  px_flags_t             bf_q;

  logic                  cv_q, cw_q;
  logic [ADDR_BITS-1:0]  ca_q;
  logic [BYTES_BITS-1:0] cb_q;
  logic [COUNT_BITS-1:0] cn_q;
  px_flags_t             cf_q;
  logic [SW-1:0]         addr_sum;

  assign xm = pix_x_i[MW-1:0];
  assign ym = pix_y_i[MW-1:0];
  assign on_screen = !pix_x_i[COORD_BITS-1] && !pix_y_i[COORD_BITS-1] &&
                     (CMPW'(xm) < CMPW'(screen_width_i)) &&
                     (CMPW'(ym) < CMPW'(screen_height_i));
  assign sized = (bytes_per_pixel_i == BPP_RGB565) || (bytes_per_pixel_i == BPP_RGB888) ||
                 (bytes_per_pixel_i == BPP_XRGB);
  assign wen = on_screen && sized && !pix_flags_i.idle;

  assign c_ready     = !cv_q || !out_stall_i;
  assign b_ready     = !bv_q || c_ready;
  assign pix_ready_o = b_ready;
  assign addr_sum    = SW'(by_q) + SW'(bx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= 1'b0;
      cv_q <= 1'b0;
    end else begin
      if (b_ready) begin
        bv_q <= pix_valid_i;
      end
      if (c_ready) begin
        cv_q <= bv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && pix_valid_i) begin
      bw_q <= wen;
      by_q <= wen ? YPW'(ym) * YPW'(row_stride_i) : '0;
      bx_q <= wen ? XPW'(xm) * XPW'(bytes_per_pixel_i) : '0;
      bb_q <= wen ? pack_color(bytes_per_pixel_i, pix_color_i) : '0;
      bn_q <= wen ? bytes_per_pixel_i[COUNT_BITS-1:0] : '0;
      bf_q <= pix_flags_i;
    end
    if (c_ready && bv_q) begin
      cw_q <= bw_q;
      ca_q <= addr_sum[ADDR_BITS-1:0];
      cb_q <= bb_q;
      cn_q <= bn_q;
      cf_q <= bf_q;
    end
  end

  assign out_valid_o    = cv_q;
  assign write_enable_o = cw_q;
  assign byte_address_o = ca_q;
  assign pixel_bytes_o  = cb_q;
  assign byte_count_o   = cn_q;
  assign last_pixel_o   = cf_q.last;
  assign line_idle_o    = cf_q.idle;

endmodule

`default_nettype wire

### design/line_rasterizer_pixel_writer_unit.sv
// Line rasterizer pixel writer: Bresenham walk, clipping and packed writes.
// An accepted word passes the walker pixel register and both writer stages.
// One word per cycle while out_stall_i is low; the Bresenham update is one step.
// Reset clears the line state (no line active) and loads the register defaults.
// Depends on lrpw_pkg, lrpw_walker and lrpw_writer.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_pixel_writer_unit import lrpw_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         kind_i,
  input  wire logic signed [COORD_BITS-1:0] start_x_i,
  input  wire logic signed [COORD_BITS-1:0] start_y_i,
  input  wire logic signed [COORD_BITS-1:0] finish_x_i,
  input  wire logic signed [COORD_BITS-1:0] finish_y_i,
  input  wire logic [COLOR_BITS-1:0]        color_rgb_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              write_enable_o,
  output logic [ADDR_BITS-1:0]              byte_address_o,
  output logic [BYTES_BITS-1:0]             pixel_bytes_o,
  output logic [COUNT_BITS-1:0]             byte_count_o,
  output logic                              last_pixel_o,
  output logic                              line_idle_o
);

  logic [SCREEN_BITS-1:0] width_q, height_q;
  logic [BPP_BITS-1:0]    bpp_q;
  logic [STRIDE_BITS-1:0] stride_q;

  logic                         in_ready;
  logic                         pix_valid, pix_ready;
  logic signed [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOR_BITS-1:0]        pix_color;
  px_flags_t                    pix_flags;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_WIDTH_RST;
      height_q <= SCREEN_HEIGHT_RST;
      bpp_q    <= BPP_RST;
      stride_q <= STRIDE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[SCREEN_BITS-1:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[SCREEN_BITS-1:0];
        CFG_BYTES_PER_PIX: bpp_q    <= cfg_data_i[BPP_BITS-1:0];
        CFG_ROW_STRIDE:    stride_q <= cfg_data_i[STRIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  lrpw_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .kind_i      (kind_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .finish_x_i  (finish_x_i),
    .finish_y_i  (finish_y_i),
    .color_rgb_i (color_rgb_i),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_color_o (pix_color),
    .pix_flags_o (pix_flags)
  );

  lrpw_writer #(
    .COORD_BITS(COORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_writer (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .screen_width_i    (width_q),
    .screen_height_i   (height_q),
    .bytes_per_pixel_i (bpp_q),
    .row_stride_i      (stride_q),
    .pix_valid_i       (pix_valid),
    .pix_ready_o       (pix_ready),
    .pix_x_i           (pix_x),
    .pix_y_i           (pix_y),
    .pix_color_i       (pix_color),
    .pix_flags_i       (pix_flags),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .write_enable_o    (write_enable_o),
    .byte_address_o    (byte_address_o),
    .pixel_bytes_o     (pixel_bytes_o),
    .byte_count_o      (byte_count_o),
    .last_pixel_o      (last_pixel_o),
    .line_idle_o       (line_idle_o)
  );

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_idle_o |-> !write_enable_o && !last_pixel_o && byte_count_o == '0)
    else $error("idle result carries a write or a last flag");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (write_enable_o == (byte_count_o != '0)))
    else $error("byte count disagrees with write enable");

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output stage");

  a_pipe_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without backpressure at the output");

endmodule

`default_nettype wire
